[hdl/bftb_pkg.sv]
// ----------------------------------------------------------------------------
// bftb_pkg
// Shared types, codes and constants of the bitmap font text blitter.
// ----------------------------------------------------------------------------
package bftb_pkg;

  // glyphs per font, printable code range, pen limit
  localparam int unsigned     GLYPHS     = 96;
  localparam logic [7:0]      FIRST_CODE = 8'd32;
  localparam logic [7:0]      LAST_CODE  = 8'd127;
  localparam logic [11:0]     PEN_MAX    = 12'd2047;

  // queue depths between the stages (powers of two)
  localparam int unsigned     CMD_DEPTH  = 4;
  localparam int unsigned     RES_DEPTH  = 4;

  // glyph geometry codes
  typedef enum logic [1:0] {
    GEOM_8X8  = 2'd0,
    GEOM_7X12 = 2'd1,
    GEOM_8X12 = 2'd2,
    GEOM_8X14 = 2'd3
  } font_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FONT_SELECT   = 2'd0,
    REG_TEXT_COLOR    = 2'd1,
    REG_SCREEN_WIDTH  = 2'd2,
    REG_SCREEN_HEIGHT = 2'd3
  } reg_e;

  // request kinds
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_DRAW = 1'b1
  } req_e;

  // configuration register set
  typedef struct packed {
    logic [1:0]  font_select;
    logic [15:0] text_color;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
  } cfg_t;

  // one input request as it arrives
  typedef struct packed {
    req_e               req_type;
    logic [1:0]         font_index;
    logic [6:0]         glyph_index;
    logic [3:0]         row_index;
    logic [7:0]         font_byte;
    logic [7:0]         char_code;
    logic               new_string;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;
  } in_t;

  // classified command handed from front to back
  typedef struct packed {
    req_e               kind;
    font_e              font;
    logic [6:0]         glyph;
    logic [3:0]         row;
    logic [7:0]         data;
    logic signed [11:0] pen_x;
    logic signed [11:0] pen_y;
  } cmd_t;

  // one drawn glyph row
  typedef struct packed {
    logic signed [11:0] row_x;
    logic signed [12:0] row_y;
    logic [7:0]         pixel_mask;
    logic [15:0]        pixel_color;
    logic               last_row;
  } res_t;

  // glyph width in pixels
  function automatic logic [3:0] glyph_cols(font_e f);
    logic [3:0] w;
    w = 4'd8;
    if (f == GEOM_7X12) begin
      w = 4'd7;
    end
    return w;
  endfunction

  // glyph height in rows
  function automatic logic [3:0] glyph_lines(font_e f);
    logic [3:0] h;
    case (f)
      GEOM_7X12: h = 4'd12;
      GEOM_8X12: h = 4'd12;
      GEOM_8X14: h = 4'd14;
      default:   h = 4'd8;
    endcase
    return h;
  endfunction

endpackage

[hdl/bftb_fifo.sv]
// ----------------------------------------------------------------------------
// bftb_fifo
// Small register-based first-in first-out queue with an occupancy count.
// ----------------------------------------------------------------------------
module bftb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  // handshake qualification
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  // pointer and count update
  always_comb begin
    wptr_d  = do_push ? wptr_q + PW'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + PW'(1) : rptr_q;
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

[hdl/bftb_front.sv]
// ----------------------------------------------------------------------------
// bftb_front
// Request intake: filters loads and codes, tracks the pen, queues commands.
// ----------------------------------------------------------------------------
module bftb_front
  import bftb_pkg::*;
#(
  parameter int unsigned FONT_COUNT = 4,
  parameter int unsigned GLYPH_ROWS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] font_select_i,
  input  logic       push_i,
  input  in_t        req_i,
  output logic       full_o,
  input  logic       cmd_full_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  logic               accept;
  logic               is_draw;
  logic               printable;
  logic               load_ok;
  font_e              font_eff;
  logic signed [11:0] pen_x_cur, pen_y_cur;
  logic [12:0]        pen_sum;
  logic signed [11:0] pen_adv;
  logic signed [11:0] pen_x_q, pen_x_d;
  logic signed [11:0] pen_y_q, pen_y_d;

  assign full_o  = cmd_full_i;
  assign accept  = push_i && !cmd_full_i;
  assign is_draw = (req_i.req_type == REQ_DRAW);

  // classification of the request
  always_comb begin
    printable = (req_i.char_code >= FIRST_CODE) && (req_i.char_code <= LAST_CODE);
    load_ok   = (32'(req_i.font_index) < FONT_COUNT)
             && (32'(req_i.glyph_index) < GLYPHS)
             && (32'(req_i.row_index) < GLYPH_ROWS);
    font_eff  = (32'(font_select_i) < FONT_COUNT) ? font_e'(font_select_i) : GEOM_8X8;
  end

  // pen position and saturating advance
  always_comb begin
    pen_x_cur = req_i.new_string ? req_i.x_pos : pen_x_q;
    pen_y_cur = req_i.new_string ? req_i.y_pos : pen_y_q;
    pen_sum   = {pen_x_cur[11], pen_x_cur} + {9'd0, glyph_cols(font_eff)};
    if (!pen_sum[12] && pen_sum[11]) begin
      pen_adv = PEN_MAX;
    end else begin
      pen_adv = pen_sum[11:0];
    end
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (accept && is_draw) begin
      pen_x_d = printable ? pen_adv : pen_x_cur;
      pen_y_d = pen_y_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
    end
  end

  // command to the back end
  always_comb begin
    cmd_push_o  = accept && (is_draw ? printable : load_ok);
    cmd_o.kind  = req_i.req_type;
    cmd_o.font  = is_draw ? font_eff : font_e'(req_i.font_index);
    cmd_o.glyph = is_draw ? 7'(req_i.char_code - FIRST_CODE) : req_i.glyph_index;
    cmd_o.row   = req_i.row_index;
    cmd_o.data  = req_i.font_byte;
    cmd_o.pen_x = pen_x_cur;
    cmd_o.pen_y = pen_y_cur;
  end

endmodule

[hdl/bftb_back.sv]
// ----------------------------------------------------------------------------
// bftb_back
// Font store and row generator: writes glyph bytes, reads one row a cycle
// while the result queue has room and clips it against the screen.
// ----------------------------------------------------------------------------
module bftb_back
  import bftb_pkg::*;
#(
  parameter int unsigned FONT_COUNT = 4,
  parameter int unsigned GLYPH_ROWS = 16,
  parameter int unsigned COLOR_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfg_t                           cfg_i,
  input  logic                           cmd_empty_i,
  input  cmd_t                           cmd_i,
  output logic                           cmd_pop_o,
  input  logic                           res_full_i,
  input  logic [$clog2(RES_DEPTH+1)-1:0] res_count_i,
  output logic                           res_push_o,
  output res_t                           res_o
);

  localparam int unsigned STORE_DEPTH = FONT_COUNT * GLYPHS * GLYPH_ROWS;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned CW          = $clog2(RES_DEPTH + 1);
  localparam int unsigned CB          = (COLOR_BITS < 16) ? COLOR_BITS : 16;
  localparam logic [16:0] COLOR_ONE   = 17'd1;
  localparam logic [15:0] COLOR_MASK  = 16'((COLOR_ONE << CB) - COLOR_ONE);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [7:0]         font_mem_q [STORE_DEPTH];
  logic [AW-1:0]      cmd_base;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic               start;
  logic               room;
  logic               issue;
  logic               last_issue;
  logic [AW-1:0]      base_q;
  logic [3:0]         dy_q, dy_d;
  logic [3:0]         fw_q, fh_q;
  logic signed [11:0] pen_x_q, pen_y_q;
  logic               rd_valid_q;
  logic [3:0]         rd_dy_q;
  logic               rd_last_q;
  logic [7:0]         rd_data_q;
  logic [12:0]        row_y;
  logic               row_on;
  logic [7:0]         col_on;

  // command dispatch
  always_comb begin
    cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;
    mem_we     = cmd_pop_o && (cmd_i.kind == REQ_LOAD);
    start      = cmd_pop_o && (cmd_i.kind == REQ_DRAW);
    cmd_base   = AW'((32'(cmd_i.font) * GLYPHS + 32'(cmd_i.glyph)) * GLYPH_ROWS);
    room       = ({1'b0, res_count_i} + (CW+1)'(rd_valid_q)) < (CW+1)'(RES_DEPTH);
    issue      = (state_q == ST_DRAW) && room;
    last_issue = issue && (dy_q == fh_q - 4'd1);
    rd_addr    = base_q + AW'(dy_q);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    dy_d    = dy_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DRAW;
          dy_d    = '0;
        end
      end
      ST_DRAW: begin
        if (issue) begin
          dy_d = dy_q + 4'd1;
        end
        if (last_issue) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      dy_q       <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      dy_q       <= dy_d;
      rd_valid_q <= issue;
    end
  end

  // character context latched at start
  always_ff @(posedge clk_i) begin
    if (start) begin
      base_q  <= cmd_base;
      fw_q    <= glyph_cols(cmd_i.font);
      fh_q    <= glyph_lines(cmd_i.font);
      pen_x_q <= cmd_i.pen_x;
      pen_y_q <= cmd_i.pen_y;
    end
    if (issue) begin
      rd_dy_q   <= dy_q;
      rd_last_q <= last_issue;
    end
  end

  // font store, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem_q[cmd_base + AW'(cmd_i.row)] <= cmd_i.data;
    end
    if (issue) begin
      rd_data_q <= font_mem_q[rd_addr];
    end
  end

  // clipping of the fetched row
  always_comb begin
    logic [12:0] px;
    row_y  = {pen_y_q[11], pen_y_q} + {9'd0, rd_dy_q};
    row_on = !row_y[12] && (row_y[11:0] < cfg_i.screen_height);
    for (int dx = 0; dx < 8; dx++) begin
      px = {pen_x_q[11], pen_x_q} + 13'(dx);
      col_on[7-dx] = (4'(dx) < fw_q) && !px[12] && (px[11:0] < cfg_i.screen_width);
    end
  end

  // result row
  always_comb begin
    res_push_o        = rd_valid_q;
    res_o.row_x       = pen_x_q;
    res_o.row_y       = row_y;
    res_o.pixel_mask  = row_on ? (rd_data_q & col_on) : 8'd0;
    res_o.pixel_color = cfg_i.text_color & COLOR_MASK;
    res_o.last_row    = rd_last_q;
  end

  // a fetched row always finds room in the result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> !res_full_i)
    else $error("result row produced with result queue full");

  // the row counter stays inside the glyph
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> (dy_q < fh_q))
    else $error("row counter beyond glyph height");

  // the final fetch closes the character and is flagged as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_issue |=> (rd_valid_q && rd_last_q && state_q == ST_IDLE))
    else $error("last row not flagged or sequencer not idle");

endmodule

[hdl/bitmap_font_text_blitter_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_font_text_blitter_unit
// Bitmap font character generator: glyph rows out of an on-chip font store.
// ----------------------------------------------------------------------------
// Requests enter through a queue-like port (push/full) and glyph rows leave
// through another (pop/empty). The front end takes one request per cycle as
// long as its command queue has room; it drops unprintable codes and
// out-of-range loads; an unprintable code does not advance the pen. The
// row generator takes no new command until all rows of a drawn character
// are fetched through the single font store port, one glyph row per cycle
// while the result queue has room. The font store is not cleared after
// reset: every glyph row must be loaded before it is drawn. Configuration is
// written through cfg_we_i/cfg_addr_i/cfg_wdata_i while the unit is idle.
// ----------------------------------------------------------------------------
module bitmap_font_text_blitter_unit
  import bftb_pkg::*;
#(
  parameter int unsigned FONT_COUNT = 4,
  parameter int unsigned GLYPH_ROWS = 16,
  parameter int unsigned COLOR_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  // requests
  input  logic               push,
  output logic               full,
  input  logic               req_type_i,
  input  logic [1:0]         font_index_i,
  input  logic [6:0]         glyph_index_i,
  input  logic [3:0]         row_index_i,
  input  logic [7:0]         font_byte_i,
  input  logic [7:0]         char_code_i,
  input  logic               new_string_i,
  input  logic signed [11:0] x_pos_i,
  input  logic signed [11:0] y_pos_i,
  // glyph rows
  output logic               empty,
  input  logic               pop,
  output logic signed [11:0] row_x_o,
  output logic signed [12:0] row_y_o,
  output logic [7:0]         pixel_mask_o,
  output logic [15:0]        pixel_color_o,
  output logic               last_row_o
);

  localparam int unsigned CCW = $clog2(CMD_DEPTH + 1);
  localparam int unsigned RCW = $clog2(RES_DEPTH + 1);

  cfg_t           cfg_q, cfg_d;
  in_t            req;
  cmd_t           cmd_in, cmd_out;
  logic           cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic [CCW-1:0] cmd_count;
  res_t           res_in, res_out;
  logic           res_push, res_full;
  logic [RCW-1:0] res_count;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_e'(cfg_addr_i))
        REG_FONT_SELECT:   cfg_d.font_select   = cfg_wdata_i[1:0];
        REG_TEXT_COLOR:    cfg_d.text_color    = cfg_wdata_i;
        REG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_wdata_i[11:0];
        REG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_wdata_i[11:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_select   <= 2'd0;
      cfg_q.text_color    <= 16'd0;
      cfg_q.screen_width  <= 12'd320;
      cfg_q.screen_height <= 12'd240;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // request bundle
  always_comb begin
    req.req_type    = req_e'(req_type_i);
    req.font_index  = font_index_i;
    req.glyph_index = glyph_index_i;
    req.row_index   = row_index_i;
    req.font_byte   = font_byte_i;
    req.char_code   = char_code_i;
    req.new_string  = new_string_i;
    req.x_pos       = x_pos_i;
    req.y_pos       = y_pos_i;
  end

  bftb_front #(
    .FONT_COUNT (FONT_COUNT),
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .font_select_i (cfg_q.font_select),
    .push_i        (push),
    .req_i         (req),
    .full_o        (full),
    .cmd_full_i    (cmd_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  // command queue between front and back
  bftb_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  bftb_back #(
    .FONT_COUNT (FONT_COUNT),
    .GLYPH_ROWS (GLYPH_ROWS),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue toward the consumer
  bftb_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  // result ports
  assign row_x_o       = res_out.row_x;
  assign row_y_o       = res_out.row_y;
  assign pixel_mask_o  = res_out.pixel_mask;
  assign pixel_color_o = res_out.pixel_color;
  assign last_row_o    = res_out.last_row;

  // command queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_count <= CCW'(CMD_DEPTH))
    else $error("command queue count out of range");

  // a push and a pop in the same cycle leave the command count unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push && cmd_pop) |=> (cmd_count == $past(cmd_count)))
    else $error("command queue count lost a simultaneous push and pop");

  // the result queue is only filled by the row generator within its room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_count == RCW'(RES_DEPTH)) |-> !res_push)
    else $error("row pushed into full result queue");

endmodule

[bench/bftb_row_checker.sv]
// ----------------------------------------------------------------------------
// bftb_row_checker
// Watches the request, glyph row and register ports of the text blitter,
// predicts every glyph row from its own copy of the font store, pen and
// registers, and compares each popped row field by field.
// ----------------------------------------------------------------------------
module bftb_row_checker
  import bftb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // register writes
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  // requests
  input  logic               push_i,
  input  logic               full_i,
  input  logic               req_type_i,
  input  logic [1:0]         font_index_i,
  input  logic [6:0]         glyph_index_i,
  input  logic [3:0]         row_index_i,
  input  logic [7:0]         font_byte_i,
  input  logic [7:0]         char_code_i,
  input  logic               new_string_i,
  input  logic signed [11:0] x_pos_i,
  input  logic signed [11:0] y_pos_i,
  // glyph rows
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic signed [11:0] row_x_i,
  input  logic signed [12:0] row_y_i,
  input  logic [7:0]         pixel_mask_i,
  input  logic [15:0]        pixel_color_i,
  input  logic               last_row_i,
  // status for the bench top
  output int                 fail_cnt_o,
  output int                 rows_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FONTS   = 4;
  localparam int GLYPH_DEPTH = 16;
  localparam int MAX_LINES   = 40;

  // predictor state
  logic [7:0] font_mem [NUM_FONTS][GLYPHS][GLYPH_DEPTH];
  font_e      sel_font;
  logic [15:0] ink;
  int         scr_w;
  int         scr_h;
  int         pen_x;
  int         pen_y;
  res_t       rows_due [$];
  int         n_fail = 0;

  // one line per mismatch, printing capped so a broken design stays readable
  task automatic report_mismatch(input string msg);
    if (n_fail < MAX_LINES) begin
      $display("[%0t] glyph row mismatch: %s", $time, msg);
    end
    n_fail++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    int fw, fh, dy, dx, px, py;
    logic [7:0] bits;
    logic [7:0] mask;
    res_t row;
    res_t due;
    if (!rst_ni) begin
      sel_font = GEOM_8X8;
      ink      = '0;
      scr_w    = 320;
      scr_h    = 240;
      pen_x    = 0;
      pen_y    = 0;
      rows_due.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (reg_e'(cfg_addr_i))
          REG_FONT_SELECT:   sel_font = font_e'(cfg_wdata_i[1:0]);
          REG_TEXT_COLOR:    ink = cfg_wdata_i;
          REG_SCREEN_WIDTH:  scr_w = int'(cfg_wdata_i[11:0]);
          REG_SCREEN_HEIGHT: scr_h = int'(cfg_wdata_i[11:0]);
          default: ;
        endcase
      end

      // accepted request: font load or character draw
      if (push_i && !full_i) begin
        if (req_type_i == REQ_LOAD) begin
          if (glyph_index_i < GLYPHS) begin
            font_mem[font_index_i][glyph_index_i][row_index_i] = font_byte_i;
          end
        end else begin
          if (new_string_i) begin
            pen_x = x_pos_i;
            pen_y = y_pos_i;
          end
          if (char_code_i >= FIRST_CODE && char_code_i <= LAST_CODE) begin
            fw = (sel_font == GEOM_7X12) ? 7 : 8;
            case (sel_font)
              GEOM_7X12, GEOM_8X12: fh = 12;
              GEOM_8X14:            fh = 14;
              default:              fh = 8;
            endcase
            for (dy = 0; dy < fh; dy++) begin
              py   = pen_y + dy;
              bits = font_mem[sel_font][char_code_i - FIRST_CODE][dy];
              mask = '0;
              // clip each pixel against the screen, rows off screen stay blank
              if (py >= 0 && py < scr_h) begin
                for (dx = 0; dx < fw; dx++) begin
                  px = pen_x + dx;
                  if (bits[7 - dx] && px >= 0 && px < scr_w) begin
                    mask[7 - dx] = 1'b1;
                  end
                end
              end
              row.row_x       = pen_x[11:0];
              row.row_y       = py[12:0];
              row.pixel_mask  = mask;
              row.pixel_color = ink;
              row.last_row    = (dy == fh - 1);
              rows_due.push_back(row);
            end
            // pen moves right by the glyph width and sticks at the top
            pen_x = (pen_x + fw > int'(PEN_MAX)) ? int'(PEN_MAX) : pen_x + fw;
          end
        end
      end

      // popped glyph row against the oldest prediction
      if (pop_i && !empty_i) begin
        if (rows_due.size() == 0) begin
          report_mismatch($sformatf("row at x %0d y %0d with no request waiting",
                                    row_x_i, row_y_i));
        end else begin
          due = rows_due.pop_front();
          if (row_x_i !== due.row_x)
            report_mismatch($sformatf("row_x %0d, expected %0d", row_x_i, due.row_x));
          if (row_y_i !== due.row_y)
            report_mismatch($sformatf("row_y %0d, expected %0d", row_y_i, due.row_y));
          if (pixel_mask_i !== due.pixel_mask)
            report_mismatch($sformatf("pixel_mask %h, expected %h at y %0d",
                                      pixel_mask_i, due.pixel_mask, due.row_y));
          if (pixel_color_i !== due.pixel_color)
            report_mismatch($sformatf("pixel_color %h, expected %h",
                                      pixel_color_i, due.pixel_color));
          if (last_row_i !== due.last_row)
            report_mismatch($sformatf("last_row %b, expected %b", last_row_i,
                                      due.last_row));
        end
      end
    end
    fail_cnt_o <= n_fail;
    rows_due_o <= rows_due.size();
  end

endmodule

[bench/tb_bitmap_font_text_blitter_unit.sv]
// ----------------------------------------------------------------------------
// tb_bitmap_font_text_blitter_unit
// Stimulus and verdict for the bitmap font text blitter.
// ----------------------------------------------------------------------------
// Loads glyphs into the font store, draws strings of characters under several
// register settings (every font, tiny and oversized screens) and lets a
// checker beside the unit predict and compare every glyph row. Both ports
// idle at random; one phase stalls the row port long enough to back the unit
// up, another runs with no idling at all.
// ----------------------------------------------------------------------------
module tb_bitmap_font_text_blitter_unit
  import bftb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 12;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 16;
  localparam int IDLE_PCT      = 29;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_addr  = '0;
  logic [15:0] cfg_wdata = '0;

  logic push = 1'b0;
  logic full;
  in_t  req_d = '0;

  logic               empty;
  logic               pop = 1'b0;
  logic signed [11:0] row_x;
  logic signed [12:0] row_y;
  logic [7:0]         pixel_mask;
  logic [15:0]        pixel_color;
  logic               last_row;

  int fail_cnt;
  int rows_pending;

  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;
  int n_items  = 0;
  int cycle_cnt = 0;

  // what the bench knows about the font store and the registers
  bit    loaded [4][GLYPHS][16];
  int    ready_glyphs [$];
  font_e cur_font = GEOM_8X8;
  int    cur_w = 320;
  int    cur_h = 240;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  bitmap_font_text_blitter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .req_type_i    (req_d.req_type),
    .font_index_i  (req_d.font_index),
    .glyph_index_i (req_d.glyph_index),
    .row_index_i   (req_d.row_index),
    .font_byte_i   (req_d.font_byte),
    .char_code_i   (req_d.char_code),
    .new_string_i  (req_d.new_string),
    .x_pos_i       (req_d.x_pos),
    .y_pos_i       (req_d.y_pos),
    .empty         (empty),
    .pop           (pop),
    .row_x_o       (row_x),
    .row_y_o       (row_y),
    .pixel_mask_o  (pixel_mask),
    .pixel_color_o (pixel_color),
    .last_row_o    (last_row)
  );

  bftb_row_checker u_rows (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .push_i        (push),
    .full_i        (full),
    .req_type_i    (req_d.req_type),
    .font_index_i  (req_d.font_index),
    .glyph_index_i (req_d.glyph_index),
    .row_index_i   (req_d.row_index),
    .font_byte_i   (req_d.font_byte),
    .char_code_i   (req_d.char_code),
    .new_string_i  (req_d.new_string),
    .x_pos_i       (req_d.x_pos),
    .y_pos_i       (req_d.y_pos),
    .empty_i       (empty),
    .pop_i         (pop),
    .row_x_i       (row_x),
    .row_y_i       (row_y),
    .pixel_mask_i  (pixel_mask),
    .pixel_color_i (pixel_color),
    .last_row_i    (last_row),
    .fail_cnt_o    (fail_cnt),
    .rows_due_o    (rows_pending)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_bitmap_font_text_blitter_unit NOT OK");
      $finish;
    end
  end

  // row port: random pops, one long hold-off on request
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // rows drawn per glyph
  function automatic int glyph_rows(font_e f);
    int h;
    case (f)
      GEOM_7X12, GEOM_8X12: h = 12;
      GEOM_8X14:            h = 14;
      default:              h = 8;
    endcase
    return h;
  endfunction

  // request with every field random, callers overwrite what matters
  function automatic in_t noise_req();
    in_t q;
    q.req_type    = req_e'(1'($urandom));
    q.font_index  = 2'($urandom);
    q.glyph_index = 7'($urandom);
    q.row_index   = 4'($urandom);
    q.font_byte   = 8'($urandom);
    q.char_code   = 8'($urandom);
    q.new_string  = 1'($urandom);
    q.x_pos       = 12'($urandom);
    q.y_pos       = 12'($urandom);
    return q;
  endfunction

  // pen coordinate, mostly around the screen edges and the pen limit
  function automatic logic [11:0] pick_pos(int span);
    int v;
    case ($urandom_range(4))
      0:       v = $urandom_range(4095);
      1:       v = int'($urandom_range(24)) - 12;
      2:       v = span - int'($urandom_range(16));
      3:       v = 2047 - int'($urandom_range(20));
      default: v = $urandom_range(span);
    endcase
    return v[11:0];
  endfunction

  function automatic int pick_glyph();
    int g;
    case ($urandom_range(9))
      0:       g = 0;
      1:       g = GLYPHS - 1;
      default: g = $urandom_range(GLYPHS - 1);
    endcase
    return g;
  endfunction

  // glyphs of one font whose drawn rows have all been loaded
  function automatic void scan_ready(font_e f);
    bit ok;
    ready_glyphs.delete();
    for (int g = 0; g < GLYPHS; g++) begin
      ok = 1'b1;
      for (int r = 0; r < glyph_rows(f); r++) begin
        ok &= loaded[f][g][r];
      end
      if (ok) begin
        ready_glyphs.push_back(g);
      end
    end
  endfunction

  // hold one request until the unit takes it
  task automatic offer(input in_t q);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push  <= 1'b1;
    req_d <= q;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    n_items++;
  endtask

  task automatic send_load(input logic [1:0] f, input logic [6:0] g,
                           input logic [3:0] r, input logic [7:0] b);
    in_t q;
    q             = noise_req();
    q.req_type    = REQ_LOAD;
    q.font_index  = f;
    q.glyph_index = g;
    q.row_index   = r;
    q.font_byte   = b;
    offer(q);
    if (g < GLYPHS) begin
      loaded[f][g][r] = 1'b1;
    end
  endtask

  task automatic send_draw(input logic [7:0] code, input logic ns,
                           input logic [11:0] x, input logic [11:0] y);
    in_t q;
    q            = noise_req();
    q.req_type   = REQ_DRAW;
    q.char_code  = code;
    q.new_string = ns;
    q.x_pos      = x;
    q.y_pos      = y;
    offer(q);
  endtask

  // every drawn row of one glyph, solid and empty rows favored
  task automatic load_glyph(input font_e f, input int g);
    logic [7:0] b;
    for (int r = 0; r < glyph_rows(f); r++) begin
      case ($urandom_range(9))
        0, 1:    b = 8'hFF;
        2:       b = 8'h00;
        default: b = 8'($urandom);
      endcase
      send_load(f, g[6:0], r[3:0], b);
    end
  endtask

  // write all four registers back to back
  task automatic set_regs(input font_e f, input logic [15:0] color, input int w,
                          input int h);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FONT_SELECT;
    cfg_wdata <= {14'($urandom), f};
    @(posedge clk_i);
    cfg_addr  <= REG_TEXT_COLOR;
    cfg_wdata <= color;
    @(posedge clk_i);
    cfg_addr  <= REG_SCREEN_WIDTH;
    cfg_wdata <= {4'($urandom), w[11:0]};
    @(posedge clk_i);
    cfg_addr  <= REG_SCREEN_HEIGHT;
    cfg_wdata <= {4'($urandom), h[11:0]};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_font = f;
    cur_w    = w & 32'hFFF;
    cur_h    = h & 32'hFFF;
  endtask

  // stop sending, wait for every predicted row, then let the unit settle
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly strings of loaded glyphs, with glyph loads, stray loads and
  // unprintable codes in between
  task automatic run_random(input int quota);
    int start, r, len;
    logic [7:0] code;
    logic ns;
    start = n_items;
    while (n_items - start < quota) begin
      r = $urandom_range(99);
      if (r < 15) begin
        send_load(2'($urandom), 7'($urandom), 4'($urandom), 8'($urandom));
      end else if (r < 25) begin
        code = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(128, 255));
        send_draw(code, 1'($urandom), pick_pos(cur_w), pick_pos(cur_h));
      end else if (r < 33) begin
        load_glyph(cur_font, pick_glyph());
      end else begin
        scan_ready(cur_font);
        if (ready_glyphs.size() == 0) begin
          load_glyph(cur_font, pick_glyph());
          scan_ready(cur_font);
        end
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          code = 8'(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]) + FIRST_CODE;
          ns   = (k == 0) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 8);
          send_draw(code, ns, pick_pos(cur_w), pick_pos(cur_h));
        end
      end
    end
  endtask

  initial begin : stim
    logic [7:0] pattern [8] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h81, 8'h7E};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: space glyph of the 8x8 font, edges of screen and pen range
    set_regs(GEOM_8X8, 16'hFFFF, 320, 240);
    for (int r = 0; r < 8; r++) begin
      send_load(GEOM_8X8, 7'd0, r[3:0], pattern[r]);
    end
    send_load(GEOM_8X14, 7'd127, 4'd15, 8'hFF);   // glyph out of range, dropped
    send_load(GEOM_8X8, 7'd96, 4'd0, 8'hFF);      // first glyph past the table
    send_load(GEOM_8X12, 7'd5, 4'd15, 8'hC3);     // last row slot, never drawn
    send_draw(FIRST_CODE, 1'b1, 12'h000, 12'h000);
    send_draw(FIRST_CODE, 1'b0, 12'h123, 12'h456);
    send_draw(8'd31, 1'b1, -12'sd3, -12'sd2);     // unprintable still moves pen
    send_draw(FIRST_CODE, 1'b0, 12'h000, 12'h000);
    send_draw(8'd128, 1'b0, 12'h000, 12'h000);
    send_draw(8'd255, 1'b1, 12'd100, 12'd100);
    send_draw(8'd0, 1'b0, 12'h000, 12'h000);
    send_draw(FIRST_CODE, 1'b1, 12'd316, 12'd236);
    send_draw(FIRST_CODE, 1'b1, 12'h7FF, 12'h7FF);
    send_draw(FIRST_CODE, 1'b0, 12'h000, 12'h000);
    send_draw(FIRST_CODE, 1'b1, 12'h800, 12'h800);
    wait_idle();

    // random phases, one register setting each
    for (int p = 1; p <= 5; p++) begin
      case (p)
        1:       set_regs(GEOM_7X12, 16'($urandom), 320, 240);
        2:       set_regs(GEOM_8X12, 16'h0000, 1, 1);
        3:       set_regs(GEOM_8X14, 16'hFFFF, 4095, 4095);
        4:       set_regs(GEOM_8X8, 16'($urandom), 2048, 2048);
        default: set_regs(font_e'($urandom_range(3)), 16'($urandom),
                          $urandom_range(1, 2048), $urandom_range(1, 2048));
      endcase
      no_idle = (p == 3);
      if (p == 1) begin
        // back the unit up behind a stalled row port
        load_glyph(cur_font, pick_glyph());
        hold_req = 1'b1;
      end
      if (p == 2) begin
        run_random(PHASE_ITEMS / 2);
        wait_idle();
        run_random(PHASE_ITEMS / 2);
      end else begin
        run_random(PHASE_ITEMS);
      end
      wait_idle();
      no_idle = 1'b0;
    end

    if (fail_cnt == 0) begin
      $display("tb_bitmap_font_text_blitter_unit OK");
    end else begin
      $display("tb_bitmap_font_text_blitter_unit NOT OK");
    end
    $finish;
  end

endmodule
